### design/packet_loss_window_meter_assert.svh
`ifndef PACKET_LOSS_WINDOW_METER_ASSERT_SVH
`define PACKET_LOSS_WINDOW_METER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plwm check failed");

// next-cycle implication, checked outside reset
`define PLWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plwm check failed");

`endif

### design/plwm_pkg.sv
package plwm_pkg;

    localparam int unsigned SLOTS_DEF = 32;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned NUM_W     = 39;
    localparam int unsigned ADDR_W    = 5;

    localparam logic [6:0] LOSS_SCALE = 7'd100;

    typedef enum logic [1:0] {
        CMD_RECV  = 2'd0,
        CMD_SEND  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_NONE    = 2'd1,
        ST_SEQ_ERR = 2'd2,
        ST_NOT_YET = 2'd3
    } t_status;

    localparam logic [2:0] REG_UNIT  = 3'd0;
    localparam logic [2:0] REG_DCU   = 3'd1;
    localparam logic [2:0] REG_DELAY = 3'd2;
    localparam logic [2:0] REG_MODE  = 3'd3;
    localparam logic [2:0] REG_START = 3'd4;

    localparam logic [15:0] UNIT_RST  = 16'd1000;
    localparam logic [5:0]  DCU_RST   = 6'd10;
    localparam logic [15:0] DELAY_RST = 16'd200;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] seq;
        logic [31:0] now_ms;
        logic [15:0] window_units;
        logic        include_current;
    } t_item;

    typedef struct packed {
        logic        did_compute;
        logic [6:0]  loss_percent;
        logic [1:0]  loss_status;
        logic [31:0] expected_count;
        logic [31:0] received_count;
        logic [31:0] computations_done;
        logic [31:0] loss_total;
    } t_result;

    // sequence bookkeeping of one slot
    typedef struct packed {
        logic [31:0] first_seq;
        logic [31:0] last_seq;
        logic [31:0] received;
    } t_slot;

endpackage

### design/plwm_ram.sv
module plwm_ram import plwm_pkg::*; #(
    parameter int unsigned DEPTH = SLOTS_DEF,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata  <= r_mem[i_raddr];
        r_rvalid <= r_valid[i_raddr];
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

### design/plwm_div.sv
module plwm_div import plwm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [31:0]      i_den,
    output logic             o_done,
    output logic [PCT_W-1:0] o_quot
);

    // restoring division, one quotient bit per cycle; quotient known below 2**PCT_W
    logic [NUM_W-1:0]         r_rem;
    logic [NUM_W-1:0]         r_trial;
    logic [PCT_W-1:0]         r_quot;
    logic [$clog2(PCT_W)-1:0] r_cnt;
    logic                     r_run;
    logic                     r_done;
    logic                     fits;

    assign fits = r_rem >= r_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= ($clog2(PCT_W))'(PCT_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_num;
            r_trial <= NUM_W'(i_den) << (PCT_W - 1);
            r_quot  <= '0;
        end else if (r_run) begin
            if (fits) begin
                r_rem <= r_rem - r_trial;
            end
            r_quot  <= {r_quot[PCT_W-2:0], fits};
            r_trial <= r_trial >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### design/packet_loss_window_meter.sv
// channel  | ports                          | transaction
// ---------+--------------------------------+------------------------------------------
// command  | start, busy, i_item            | taken at an edge with start high, busy low
// result   | o_done, o_result               | one cycle with o_done high, no stall
// config   | psel, penable, pwrite, paddr.. | apb write/read, pready tied high
//
// receive and send read the current slot from the slot table, then the following slot, and
//   write back in the same cycle as the second read arrives, then drive the result
// a tick that closes or waits checks its slot time, then drives the result; one that computes,
//   and a query, walk the slot table through its single read port one window slot at a time,
//   then multiply and divide when the loss is nonzero
// synchronous active-low reset; slot entries read as zero until first written
// the result is shown for exactly one cycle, the receiver cannot stall it
`include "packet_loss_window_meter_assert.svh"

module packet_loss_window_meter import plwm_pkg::*; #(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    // result channel
    output logic              o_done,
    output t_result           o_result,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned SW = $clog2(SLOTS);
    localparam int unsigned NW = $clog2(SLOTS + 1);
    localparam int unsigned TW = SW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_C, S_RD_F, S_TK_A, S_TK_C,
        S_W0, S_W1, S_W2, S_SUMRD, S_SUMAC,
        S_CHK, S_MUL, S_DSTART, S_DIV, S_WEND, S_FIN
    } t_state;

    // ring index helpers
    function automatic logic [SW-1:0] inc_idx(input logic [SW-1:0] x);
        inc_idx = (x == SW'(SLOTS - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [SW-1:0] dec_idx(input logic [SW-1:0] x);
        dec_idx = (x == '0) ? SW'(SLOTS - 1) : x - 1'b1;
    endfunction

    // configuration registers
    logic [15:0] r_unit;
    logic [5:0]  r_dcu;
    logic [15:0] r_delay;
    logic        r_mode;
    logic [31:0] r_start_time;

    // block state
    t_state      r_state;
    t_item       r_item;
    logic [SW-1:0] r_cur;
    logic [SW-1:0] r_fol;
    logic        r_seen;
    logic        r_await;
    logic [6:0]  r_last_pct;
    logic [1:0]  r_last_st;
    logic [31:0] r_last_exp;
    logic [31:0] r_last_rec;
    logic [31:0] r_vcomp;
    logic [31:0] r_psum;
    logic        r_did;
    logic        r_strobe;
    t_result     r_result;

    // window walk
    t_slot       r_cent;
    logic [SW-1:0] r_end;
    logic [15:0] r_units;
    logic        r_deflt;
    logic [SW-1:0] r_beg;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_left;
    logic [SW-1:0] r_idx;
    logic [31:0] r_laste;
    logic [31:0] r_should;
    logic [31:0] r_sum;
    logic [31:0] r_diff;
    logic [NUM_W-1:0] r_num;
    logic [6:0]  r_wpct;
    logic [1:0]  r_wst;
    logic [31:0] r_wexp;
    logic [31:0] r_wrec;

    // memory ports
    logic          a_we;
    logic [SW-1:0] a_waddr;
    logic [31:0]   a_wdata;
    logic [SW-1:0] a_raddr;
    logic [31:0]   a_rdata;
    logic          b_we;
    logic [SW-1:0] b_waddr;
    t_slot         b_wdata;
    logic [SW-1:0] b_raddr;
    t_slot         b_rdata;

    logic          cfg_wr;
    logic [2:0]    cfg_idx;
    logic          accept;
    logic          in_cur;
    logic          in_fol;
    logic          tick_due;
    logic          close_due;
    logic [NW-1:0] n_c;
    logic [TW-1:0] t_c;
    logic [SW-1:0] beg_c;
    logic          div_start;
    logic          div_done;
    logic [PCT_W-1:0] div_quot;
    t_slot         s_ent;

    assign accept  = start && !busy;
    assign busy    = r_state != S_IDLE;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    // slot start times live apart so the start-time register can seed slot zero
    plwm_ram #(.DEPTH(SLOTS), .WIDTH(32)) u_time_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    plwm_ram #(.DEPTH(SLOTS), .WIDTH($bits(t_slot))) u_seq_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    plwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_should),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign div_start = r_state == S_DSTART;

    // window length and first slot, zero or oversize means the whole ring
    assign n_c   = (r_units == '0 || r_units > 16'(SLOTS)) ? NW'(SLOTS) : NW'(r_units);
    assign t_c   = TW'(r_end) + TW'(SLOTS + 1) - TW'(n_c);
    assign beg_c = (t_c >= TW'(SLOTS)) ? SW'(t_c - TW'(SLOTS)) : SW'(t_c);

    // in S_RD_F the current slot sits in r_cent and the following slot on b_rdata
    assign in_cur = r_item.seq >= r_cent.first_seq && r_item.seq <= r_cent.last_seq;
    assign in_fol = r_item.seq >= b_rdata.first_seq && r_item.seq <= b_rdata.last_seq;
    assign s_ent  = r_await ? b_rdata : r_cent;

    // time sums taken one bit wider so they never wrap
    assign close_due = {1'b0, r_item.now_ms} >= ({1'b0, a_rdata} + 33'(r_unit));
    assign tick_due  = {1'b0, r_item.now_ms} >= ({1'b0, a_rdata} + 33'(r_delay));

    // memory addressing and write-back
    always_comb begin
        a_we    = 1'b0;
        a_waddr = '0;
        a_wdata = pwdata;
        a_raddr = r_cur;
        b_we    = 1'b0;
        b_waddr = r_cur;
        b_wdata = r_cent;
        b_raddr = r_cur;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.command == CMD_TICK && r_await) begin
                    a_raddr = r_fol;
                end
                // start-time write also seeds slot zero
                if (cfg_wr && cfg_idx == REG_START) begin
                    a_we = 1'b1;
                end
            end
            S_RD_C: begin
                b_raddr = r_fol;
            end
            S_RD_F: begin
                if (r_item.command == CMD_RECV) begin
                    if (!r_seen && !r_mode) begin
                        b_we    = 1'b1;
                        b_waddr = r_fol;
                        b_wdata = '{r_item.seq, r_item.seq, b_rdata.received + 1'b1};
                    end else if (in_cur) begin
                        b_we    = 1'b1;
                        b_wdata = '{r_cent.first_seq, r_cent.last_seq,
                                    r_cent.received + 1'b1};
                    end else if (r_mode) begin
                        if (r_await && in_fol) begin
                            b_we    = 1'b1;
                            b_waddr = r_fol;
                            b_wdata = '{b_rdata.first_seq, b_rdata.last_seq,
                                        b_rdata.received + 1'b1};
                        end
                    end else if (r_item.seq > r_cent.last_seq) begin
                        b_we = 1'b1;
                        if (!r_await) begin
                            b_wdata = '{r_cent.first_seq, r_item.seq,
                                        r_cent.received + 1'b1};
                        end else begin
                            b_waddr = r_fol;
                            b_wdata = '{b_rdata.first_seq,
                                        (r_item.seq > b_rdata.last_seq) ?
                                            r_item.seq : b_rdata.last_seq,
                                        b_rdata.received + 1'b1};
                        end
                    end
                end else if (r_mode) begin
                    // send: start or widen the open slot's sequence range
                    if (!r_seen) begin
                        b_we    = 1'b1;
                        b_waddr = r_fol;
                        b_wdata = '{r_item.seq, r_item.seq, b_rdata.received};
                    end else begin
                        b_waddr = r_await ? r_fol : r_cur;
                        if (r_item.seq > s_ent.last_seq) begin
                            b_we    = 1'b1;
                            b_wdata = '{s_ent.first_seq, r_item.seq, s_ent.received};
                        end else if (r_item.seq < s_ent.first_seq) begin
                            b_we    = 1'b1;
                            b_wdata = '{r_item.seq, s_ent.last_seq, s_ent.received};
                        end
                    end
                end
            end
            S_TK_C: begin
                // close: open the next slot at now, seeded from the closing slot
                if (close_due) begin
                    a_we    = 1'b1;
                    a_waddr = inc_idx(r_cur);
                    a_wdata = r_item.now_ms;
                    b_we    = 1'b1;
                    b_waddr = inc_idx(r_cur);
                    b_wdata = '{b_rdata.last_seq, b_rdata.last_seq, 32'd0};
                end
            end
            S_W0: begin
                b_raddr = r_end;
            end
            S_W1: begin
                b_raddr = r_beg;
            end
            S_SUMRD: begin
                b_raddr = r_idx;
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit       <= UNIT_RST;
            r_dcu        <= DCU_RST;
            r_delay      <= DELAY_RST;
            r_mode       <= 1'b0;
            r_start_time <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_UNIT:  r_unit       <= pwdata[15:0];
                REG_DCU:   r_dcu        <= pwdata[5:0];
                REG_DELAY: r_delay      <= pwdata[15:0];
                REG_MODE:  r_mode       <= pwdata[0];
                REG_START: r_start_time <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_UNIT:  prdata = {16'd0, r_unit};
            REG_DCU:   prdata = {26'd0, r_dcu};
            REG_DELAY: prdata = {16'd0, r_delay};
            REG_MODE:  prdata = {31'd0, r_mode};
            REG_START: prdata = r_start_time;
            default:   prdata = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur      <= '0;
            r_fol      <= '0;
            r_seen     <= 1'b0;
            r_await    <= 1'b0;
            r_last_pct <= '0;
            r_last_st  <= ST_NOT_YET;
            r_last_exp <= '0;
            r_last_rec <= '0;
            r_vcomp    <= '0;
            r_psum     <= '0;
            r_did      <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item  <= i_item;
                        r_did   <= 1'b0;
                        r_deflt <= 1'b0;
                        r_end   <= i_item.include_current ? r_cur : dec_idx(r_cur);
                        r_units <= i_item.window_units;
                        unique case (i_item.command)
                            CMD_RECV, CMD_SEND: r_state <= S_RD_C;
                            CMD_TICK:           r_state <= r_await ? S_TK_A : S_TK_C;
                            CMD_QUERY:          r_state <= S_W0;
                            default:            r_state <= S_FIN;
                        endcase
                    end
                end
                S_RD_C: begin
                    r_cent  <= b_rdata;
                    r_state <= S_RD_F;
                end
                S_RD_F: begin
                    if (!r_seen && ((r_item.command == CMD_RECV && !r_mode) ||
                                    (r_item.command == CMD_SEND && r_mode))) begin
                        r_seen <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_TK_A: begin
                    if (tick_due) begin
                        r_end   <= r_cur;
                        r_units <= 16'(r_dcu);
                        r_deflt <= 1'b1;
                        r_state <= S_W0;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_TK_C: begin
                    if (close_due) begin
                        r_fol   <= inc_idx(r_cur);
                        r_await <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_W0: begin
                    r_beg   <= beg_c;
                    r_n     <= n_c;
                    r_state <= S_W1;
                end
                S_W1: begin
                    r_laste <= b_rdata.last_seq;
                    r_state <= S_W2;
                end
                S_W2: begin
                    if (r_laste < b_rdata.first_seq) begin
                        // sequence went backwards across the window
                        r_wpct  <= '0;
                        r_wst   <= ST_SEQ_ERR;
                        r_wexp  <= '0;
                        r_wrec  <= '0;
                        r_state <= S_WEND;
                    end else begin
                        r_should <= r_laste - b_rdata.first_seq;
                        r_sum    <= b_rdata.received;
                        r_idx    <= inc_idx(r_beg);
                        r_left   <= r_n - 1'b1;
                        r_state  <= (r_n == NW'(1)) ? S_CHK : S_SUMRD;
                    end
                end
                S_SUMRD: begin
                    r_idx   <= inc_idx(r_idx);
                    r_state <= S_SUMAC;
                end
                S_SUMAC: begin
                    r_sum   <= r_sum + b_rdata.received;
                    r_left  <= r_left - 1'b1;
                    r_state <= (r_left == NW'(1)) ? S_CHK : S_SUMRD;
                end
                S_CHK: begin
                    r_wexp <= r_should;
                    r_wrec <= r_sum;
                    r_wpct <= '0;
                    if (r_should == '0) begin
                        r_wst   <= ST_NONE;
                        r_state <= S_WEND;
                    end else if (r_sum >= r_should) begin
                        r_wst   <= ST_VALID;
                        r_state <= S_WEND;
                    end else begin
                        r_diff  <= r_should - r_sum;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num   <= NUM_W'(r_diff) * NUM_W'(LOSS_SCALE);
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_wpct  <= div_quot;
                        r_wst   <= ST_VALID;
                        r_state <= S_WEND;
                    end
                end
                S_WEND: begin
                    // default window closes out the waiting slot
                    if (r_deflt) begin
                        r_last_pct <= r_wpct;
                        r_last_st  <= r_wst;
                        r_last_exp <= r_wexp;
                        r_last_rec <= r_wrec;
                        if (r_wst == ST_VALID) begin
                            r_vcomp <= r_vcomp + 1'b1;
                            r_psum  <= r_psum + 32'(r_wpct);
                        end
                        r_cur   <= r_fol;
                        r_await <= 1'b0;
                        r_did   <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register, loaded as the transaction finishes
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_result.did_compute       <= r_did;
            r_result.computations_done <= r_vcomp;
            r_result.loss_total        <= r_psum;
            if (r_item.command == CMD_QUERY) begin
                r_result.loss_percent   <= (r_wst == ST_VALID) ? r_wpct : '0;
                r_result.loss_status    <= r_wst;
                r_result.expected_count <= r_wexp;
                r_result.received_count <= r_wrec;
            end else begin
                r_result.loss_percent   <= (r_last_st == ST_VALID) ? r_last_pct : '0;
                r_result.loss_status    <= r_last_st;
                r_result.expected_count <= r_last_exp;
                r_result.received_count <= r_last_rec;
            end
        end
    end

    assign o_done   = r_strobe;
    assign o_result = r_result;

    `PLWM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `PLWM_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_done, !o_done)
    `PLWM_ASSERT_NOW(a_fol_next, i_clk, i_rst_n, r_await, r_fol == inc_idx(r_cur))
    `PLWM_ASSERT_NOW(a_did_tick, i_clk, i_rst_n, o_done && o_result.did_compute,
        r_item.command == CMD_TICK)

endmodule
